FILE: rtl/core/tta_pkg.sv
// tta_pkg: field widths, clamp helpers and the command/status structs
// shared by the tile address generator controller, datapath and top level
// no dependencies
package tta_pkg;

   localparam int DIM_W      = 13;
   localparam int TILE_W     = 9;
   localparam int NBUF_W     = 5;
   localparam int BIDX_W     = 4;
   localparam int ADDR_W     = 32;
   localparam int RSIZE_W    = 17;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;
   localparam int FACT_TR_W  = DIM_W + TILE_W;

   localparam logic [DIM_W-1:0]  DIM_MAX  = 13'd4096;
   localparam logic [TILE_W-1:0] TILE_MAX = 9'd256;
   localparam logic [NBUF_W-1:0] NBUF_MAX = 5'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILE_COLS    = 2'd0,
      CSR_TILE_ROWS    = 2'd1,
      CSR_BUFFER_COUNT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic load;
      logic count_cols;
      logic count_rows;
      logic mul_first;
      logic mul_second;
      logic emit;
      logic emit_err;
   } tta_cmd_type;

   typedef struct packed {
      logic col_more;
      logic row_more;
      logic too_large;
      logic out_free;
      logic tile_last;
   } tta_status_type;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [TILE_W-1:0] clamp_tile(input logic [TILE_W-1:0] v);
      logic [TILE_W-1:0] r;
      if (v == '0) begin
         r = TILE_W'(1);
      end else if (v > TILE_MAX) begin
         r = TILE_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

   function automatic logic [NBUF_W-1:0] clamp_nbuf(input logic [NBUF_W-1:0] v);
      logic [NBUF_W-1:0] r;
      if (v == '0) begin
         r = NBUF_W'(1);
      end else if (v > NBUF_MAX) begin
         r = NBUF_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

FILE: rtl/core/tta_if.sv
// tta_req_if and tta_rsp_if: valid/ready channels for partition requests
// and tile descriptors
// depends on tta_pkg
interface tta_req_if import tta_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [DIM_W-1:0]  plane_height;
   logic [DIM_W-1:0]  plane_width;
   logic              planar_layout;
   logic [DIM_W-1:0]  channel_count;
   logic [ADDR_W-1:0] base_address;

   modport source (
      output valid, plane_height, plane_width, planar_layout, channel_count,
             base_address,
      input  ready
   );
   modport sink (
      input  valid, plane_height, plane_width, planar_layout, channel_count,
             base_address,
      output ready
   );
endinterface

interface tta_rsp_if import tta_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [ADDR_W-1:0]  order_number;
   logic [ADDR_W-1:0]  tile_address;
   logic [DIM_W-1:0]   address_factor;
   logic [TILE_W-1:0]  cur_tile_cols;
   logic [TILE_W-1:0]  cur_tile_rows;
   logic [DIM_W-1:0]   row_length;
   logic [DIM_W-1:0]   column_length;
   logic [BIDX_W-1:0]  buffer_index;
   logic [RSIZE_W-1:0] request_size;
   logic               last;
   logic               error;

   modport source (
      output valid, order_number, tile_address, address_factor, cur_tile_cols,
             cur_tile_rows, row_length, column_length, buffer_index,
             request_size, last, error,
      input  ready
   );
   modport sink (
      input  valid, order_number, tile_address, address_factor, cur_tile_cols,
             cur_tile_rows, row_length, column_length, buffer_index,
             request_size, last, error,
      output ready
   );
endinterface

FILE: rtl/core/tta_ctrl.sv
// tta_ctrl: sequencer for one partition request (count tiles, check grid,
// precompute strides, emit descriptors)
// depends on tta_pkg
module tta_ctrl import tta_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  tta_status_type status,
   output tta_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_COLS,
      S_ROWS,
      S_CHECK,
      S_MUL1,
      S_MUL2,
      S_EMIT,
      S_ERROR
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_COLS;
            end
         end
         S_COLS: begin
            cmd.count_cols = 1'b1;
            if (!status.col_more) begin
               state_in = S_ROWS;
            end
         end
         S_ROWS: begin
            cmd.count_rows = 1'b1;
            if (!status.row_more) begin
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            state_in = status.too_large ? S_ERROR : S_MUL1;
         end
         S_MUL1: begin
            cmd.mul_first = 1'b1;
            state_in      = S_MUL2;
         end
         S_MUL2: begin
            cmd.mul_second = 1'b1;
            state_in       = S_EMIT;
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.tile_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         S_ERROR: begin
            if (status.out_free) begin
               cmd.emit_err = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: rtl/core/tta_dp.sv
// tta_dp: configuration registers, tile counting, stride multipliers,
// address walk and the descriptor output register
// depends on tta_pkg
module tta_dp import tta_pkg::*; #(
   parameter int MAX_TILES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic [DIM_W-1:0]      plane_height,
   input  logic [DIM_W-1:0]      plane_width,
   input  logic                  planar_layout,
   input  logic [DIM_W-1:0]      channel_count,
   input  logic [ADDR_W-1:0]     base_address,
   input  tta_cmd_type           cmd,
   output tta_status_type        status,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [ADDR_W-1:0]     order_number,
   output logic [ADDR_W-1:0]     tile_address,
   output logic [DIM_W-1:0]      address_factor,
   output logic [TILE_W-1:0]     cur_tile_cols,
   output logic [TILE_W-1:0]     cur_tile_rows,
   output logic [DIM_W-1:0]      row_length,
   output logic [DIM_W-1:0]      column_length,
   output logic [BIDX_W-1:0]     buffer_index,
   output logic [RSIZE_W-1:0]    request_size,
   output logic                  last,
   output logic                  error
);

   localparam int CNT_W = $clog2(MAX_TILES + 2);
   localparam logic [CNT_W-1:0]   MAX_CNT   = CNT_W'(MAX_TILES);
   localparam logic [2*CNT_W-1:0] MAX_TOTAL = (2 * CNT_W)'(MAX_TILES);

   // configuration
   logic [TILE_W-1:0] tile_cols_ff;
   logic [TILE_W-1:0] tile_rows_ff;
   logic [NBUF_W-1:0] nbuf_ff;

   // control state
   logic              rsp_valid_ff;
   logic [ADDR_W-1:0] order_ff;

   // per request working registers
   logic [DIM_W-1:0]     h_ff;
   logic [DIM_W-1:0]     w_ff;
   logic [DIM_W-1:0]     factor_ff;
   logic [DIM_W-1:0]     rem_w_ff;
   logic [DIM_W-1:0]     rem_h_ff;
   logic [CNT_W-1:0]     nw_ff;
   logic [CNT_W-1:0]     nh_ff;
   logic [CNT_W-1:0]     col_ff;
   logic [CNT_W-1:0]     row_ff;
   logic [BIDX_W-1:0]    buf_ff;
   logic [FACT_TR_W-1:0] fact_tr_ff;
   logic [FACT_TR_W-1:0] col_step_ff;
   logic [ADDR_W-1:0]    row_step_ff;
   logic [ADDR_W-1:0]    row_addr_ff;
   logic [ADDR_W-1:0]    cur_addr_ff;

   // descriptor register
   logic [ADDR_W-1:0]  order_out_ff;
   logic [ADDR_W-1:0]  addr_out_ff;
   logic [DIM_W-1:0]   factor_out_ff;
   logic [TILE_W-1:0]  cols_out_ff;
   logic [TILE_W-1:0]  rows_out_ff;
   logic [DIM_W-1:0]   w_out_ff;
   logic [DIM_W-1:0]   h_out_ff;
   logic [BIDX_W-1:0]  buf_out_ff;
   logic [RSIZE_W-1:0] size_out_ff;
   logic               last_out_ff;
   logic               error_out_ff;

   logic [TILE_W-1:0]          tc;
   logic [TILE_W-1:0]          tr;
   logic [NBUF_W-1:0]          nb;
   logic                       col_last;
   logic                       row_last;
   logic [TILE_W-1:0]          cur_cols;
   logic [TILE_W-1:0]          cur_rows;
   logic [2*TILE_W-1:0]        size_prod;
   logic [2*CNT_W-1:0]         total;
   logic [FACT_TR_W-1:0]       fact_tr_in;
   logic [FACT_TR_W-1:0]       col_step_in;
   logic [ADDR_W-1:0]          row_prod;
   logic [ADDR_W-1:0]          row_next;
   logic [NBUF_W-1:0]          buf_inc;
   logic [BIDX_W-1:0]          buf_in;

   assign tc = clamp_tile(tile_cols_ff);
   assign tr = clamp_tile(tile_rows_ff);
   assign nb = clamp_nbuf(nbuf_ff);

   assign col_last  = (CNT_W'(col_ff + 1'b1) == nw_ff);
   assign row_last  = (CNT_W'(row_ff + 1'b1) == nh_ff);
   assign cur_cols  = col_last ? rem_w_ff[TILE_W-1:0] : tc;
   assign cur_rows  = row_last ? rem_h_ff[TILE_W-1:0] : tr;
   assign size_prod = (2*TILE_W)'(cur_cols) * (2*TILE_W)'(cur_rows);
   assign total     = (2*CNT_W)'(nw_ff) * (2*CNT_W)'(nh_ff);

   assign fact_tr_in  = FACT_TR_W'(factor_ff) * FACT_TR_W'(tr);
   assign col_step_in = FACT_TR_W'(factor_ff) * FACT_TR_W'(tc);
   assign row_prod    = ADDR_W'(fact_tr_ff) * ADDR_W'(w_ff);
   assign row_next    = row_addr_ff + row_step_ff;

   assign buf_inc = NBUF_W'(buf_ff) + NBUF_W'(1);
   assign buf_in  = (buf_inc < nb) ? buf_inc[BIDX_W-1:0] : '0;

   assign status.col_more  = (DIM_W'(tc) < rem_w_ff) && (nw_ff <= MAX_CNT);
   assign status.row_more  = (DIM_W'(tr) < rem_h_ff) && (nh_ff <= MAX_CNT);
   assign status.too_large = (nw_ff > MAX_CNT) || (nh_ff > MAX_CNT) || (total > MAX_TOTAL);
   assign status.out_free  = !rsp_valid_ff || rsp_ready;
   assign status.tile_last = col_last && row_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_cols_ff <= TILE_W'(16);
         tile_rows_ff <= TILE_W'(16);
         nbuf_ff      <= NBUF_W'(1);
         order_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index)
               CSR_TILE_COLS:    tile_cols_ff <= csr_wdata;
               CSR_TILE_ROWS:    tile_rows_ff <= csr_wdata;
               CSR_BUFFER_COUNT: nbuf_ff      <= csr_wdata[NBUF_W-1:0];
               default: ;
            endcase
         end
         if (cmd.emit) begin
            order_ff <= order_ff + ADDR_W'(1);
         end
         if (cmd.emit || cmd.emit_err) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         h_ff        <= clamp_dim(plane_height);
         w_ff        <= clamp_dim(plane_width);
         factor_ff   <= planar_layout ? DIM_W'(1) : clamp_dim(channel_count);
         rem_w_ff    <= clamp_dim(plane_width);
         rem_h_ff    <= clamp_dim(plane_height);
         nw_ff       <= CNT_W'(1);
         nh_ff       <= CNT_W'(1);
         col_ff      <= '0;
         row_ff      <= '0;
         buf_ff      <= '0;
         row_addr_ff <= base_address;
         cur_addr_ff <= base_address;
      end
      if (cmd.count_cols && status.col_more) begin
         rem_w_ff <= rem_w_ff - DIM_W'(tc);
         nw_ff    <= nw_ff + CNT_W'(1);
      end
      if (cmd.count_rows && status.row_more) begin
         rem_h_ff <= rem_h_ff - DIM_W'(tr);
         nh_ff    <= nh_ff + CNT_W'(1);
      end
      if (cmd.mul_first) begin
         fact_tr_ff  <= fact_tr_in;
         col_step_ff <= col_step_in;
      end
      if (cmd.mul_second) begin
         row_step_ff <= row_prod;
      end
      if (cmd.emit) begin
         if (col_last) begin
            col_ff      <= '0;
            row_ff      <= row_ff + CNT_W'(1);
            row_addr_ff <= row_next;
            cur_addr_ff <= row_next;
            buf_ff      <= buf_in;
         end else begin
            col_ff      <= col_ff + CNT_W'(1);
            cur_addr_ff <= cur_addr_ff + ADDR_W'(col_step_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         order_out_ff  <= order_ff;
         addr_out_ff   <= cur_addr_ff;
         factor_out_ff <= factor_ff;
         cols_out_ff   <= cur_cols;
         rows_out_ff   <= cur_rows;
         w_out_ff      <= w_ff;
         h_out_ff      <= h_ff;
         buf_out_ff    <= buf_ff;
         size_out_ff   <= size_prod[RSIZE_W-1:0];
         last_out_ff   <= col_last && row_last;
         error_out_ff  <= 1'b0;
      end else if (cmd.emit_err) begin
         order_out_ff  <= '0;
         addr_out_ff   <= '0;
         factor_out_ff <= '0;
         cols_out_ff   <= '0;
         rows_out_ff   <= '0;
         w_out_ff      <= '0;
         h_out_ff      <= '0;
         buf_out_ff    <= '0;
         size_out_ff   <= '0;
         last_out_ff   <= 1'b1;
         error_out_ff  <= 1'b1;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign order_number   = order_out_ff;
   assign tile_address   = addr_out_ff;
   assign address_factor = factor_out_ff;
   assign cur_tile_cols  = cols_out_ff;
   assign cur_tile_rows  = rows_out_ff;
   assign row_length     = w_out_ff;
   assign column_length  = h_out_ff;
   assign buffer_index   = buf_out_ff;
   assign request_size   = size_out_ff;
   assign last           = last_out_ff;
   assign error          = error_out_ff;

endmodule

FILE: rtl/core/tensor_tile_address_generator_top.sv
// tensor_tile_address_generator_top: splits a tensor plane into tiles and
// emits one address descriptor per tile
// depends on tta_pkg, tta_req_if, tta_rsp_if, tta_ctrl, tta_dp
//
//   channel   dir   ports                         moves
//   req_ch    in    valid/ready + 5 fields        partition request
//   rsp_ch    out   valid/ready + 11 fields       tile descriptor or error
//   csr_*     in    csr_we, csr_index, csr_wdata  tile_cols, tile_rows, buffer_count
//
// setup per request: accept, tile counting by repeated subtraction, a grid check
// and the stride multiplies; then one descriptor per cycle from the output register
// while rsp_ready allows, 1 to MAX_TILES per request
// a new request is taken once the last descriptor is loaded into the output register
// reset (synchronous) clears the order counter and restores 16/16/1; no clearing pass
// rsp_ready low holds the output register and pauses the address walk
module tensor_tile_address_generator_top import tta_pkg::*; #(
   parameter int MAX_TILES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   tta_req_if.sink               req_ch,
   tta_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   tta_cmd_type    cmd;
   tta_status_type status;

   tta_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   tta_dp #(
      .MAX_TILES (MAX_TILES)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .plane_height   (req_ch.plane_height),
      .plane_width    (req_ch.plane_width),
      .planar_layout  (req_ch.planar_layout),
      .channel_count  (req_ch.channel_count),
      .base_address   (req_ch.base_address),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .order_number   (rsp_ch.order_number),
      .tile_address   (rsp_ch.tile_address),
      .address_factor (rsp_ch.address_factor),
      .cur_tile_cols  (rsp_ch.cur_tile_cols),
      .cur_tile_rows  (rsp_ch.cur_tile_rows),
      .row_length     (rsp_ch.row_length),
      .column_length  (rsp_ch.column_length),
      .buffer_index   (rsp_ch.buffer_index),
      .request_size   (rsp_ch.request_size),
      .last           (rsp_ch.last),
      .error          (rsp_ch.error)
   );

   // no request taken while a descriptor is being produced
   assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |-> !cmd.emit && !cmd.emit_err)
      else $error("request accepted during descriptor emission");

   // after the final tile the sequencer is back to taking requests
   assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.tile_last |=> req_ch.ready)
      else $error("not idle after last tile");

   // error result is a lone final result with an empty request size
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.error |-> rsp_ch.last && rsp_ch.request_size == '0)
      else $error("malformed error result");

   // a real tile always has a nonzero size
   assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && !rsp_ch.error |-> rsp_ch.request_size != '0)
      else $error("empty tile descriptor");

endmodule

FILE: verif/tta_descriptor_check.sv
// tta_descriptor_check: predicts the tile descriptors of every partition request
// from its own copy of the tile registers and order counter, and compares them
// with the descriptor channel; depends on tta_pkg, tta_req_if and tta_rsp_if
module tta_descriptor_check import tta_pkg::*; #(
   parameter int MAX_TILES = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   tta_req_if                    req_ch,
   tta_rsp_if                    rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output int                    mismatch_count,
   output int                    pending_count
);

   typedef struct {
      logic [ADDR_W-1:0]  order_number;
      logic [ADDR_W-1:0]  tile_address;
      logic [DIM_W-1:0]   address_factor;
      logic [TILE_W-1:0]  cur_tile_cols;
      logic [TILE_W-1:0]  cur_tile_rows;
      logic [DIM_W-1:0]   row_length;
      logic [DIM_W-1:0]   column_length;
      logic [BIDX_W-1:0]  buffer_index;
      logic [RSIZE_W-1:0] request_size;
      logic               last;
      logic               error;
   } tile_descriptor_type;

   tile_descriptor_type descriptors_due[$];
   logic [TILE_W-1:0]   cols_setting;
   logic [TILE_W-1:0]   rows_setting;
   logic [NBUF_W-1:0]   nbuf_setting;
   logic [ADDR_W-1:0]   tile_order;

   // zero counts as one, anything above the top of the range as the top
   function automatic int bounded(input int v, input int hi);
      if (v == 0) return 1;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic void predict_partition(
      input logic [DIM_W-1:0]  height_raw,
      input logic [DIM_W-1:0]  width_raw,
      input logic              planar,
      input logic [DIM_W-1:0]  chans_raw,
      input logic [ADDR_W-1:0] base
   );
      int h, w, factor, tc, tr, nb, nh, nw, rows, cols, bank;
      logic [63:0] offset;
      logic [63:0] addr;
      tile_descriptor_type d;
      h = bounded(int'(height_raw), 4096);
      w = bounded(int'(width_raw), 4096);
      factor = planar ? 1 : bounded(int'(chans_raw), 4096);
      tc = bounded(int'(cols_setting), 256);
      tr = bounded(int'(rows_setting), 256);
      nb = bounded(int'(nbuf_setting), 16);
      nh = (h - 1) / tr + 1;
      nw = (w - 1) / tc + 1;
      d = '{default: '0};
      if (nh * nw > MAX_TILES) begin
         d.last = 1'b1;
         d.error = 1'b1;
         descriptors_due = {descriptors_due, d};
         return;
      end
      bank = 0;
      for (int r = 0; r < nh; r++) begin
         rows = (r == nh - 1) ? h - (nh - 1) * tr : tr;
         for (int c = 0; c < nw; c++) begin
            cols = (c == nw - 1) ? w - (nw - 1) * tc : tc;
            offset = 64'(r) * 64'(tr) * 64'(w) + 64'(c) * 64'(tc);
            addr = 64'(base) + 64'(factor) * offset;
            d.order_number = tile_order;
            d.tile_address = addr[ADDR_W-1:0];
            d.address_factor = DIM_W'(factor);
            d.cur_tile_cols = TILE_W'(cols);
            d.cur_tile_rows = TILE_W'(rows);
            d.row_length = DIM_W'(w);
            d.column_length = DIM_W'(h);
            d.buffer_index = BIDX_W'(bank);
            d.request_size = RSIZE_W'(rows * cols);
            d.last = (r == nh - 1) && (c == nw - 1);
            d.error = 1'b0;
            descriptors_due = {descriptors_due, d};
            tile_order = tile_order + 1'b1;
         end
         bank = (bank + 1 < nb) ? bank + 1 : 0;
      end
   endfunction

   task automatic compare_field(input string label, input logic [31:0] want,
                                input logic [31:0] got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      end
   endtask

   task automatic check_descriptor();
      tile_descriptor_type want;
      if (descriptors_due.size() == 0) begin
         mismatch_count++;
         $display("%0t: unexpected descriptor, expected none, actual order %0h addr %0h",
                  $time, rsp_ch.order_number, rsp_ch.tile_address);
         return;
      end
      want = descriptors_due.pop_front();
      compare_field("order_number", want.order_number, rsp_ch.order_number);
      compare_field("tile_address", want.tile_address, rsp_ch.tile_address);
      compare_field("address_factor", want.address_factor, rsp_ch.address_factor);
      compare_field("cur_tile_cols", want.cur_tile_cols, rsp_ch.cur_tile_cols);
      compare_field("cur_tile_rows", want.cur_tile_rows, rsp_ch.cur_tile_rows);
      compare_field("row_length", want.row_length, rsp_ch.row_length);
      compare_field("column_length", want.column_length, rsp_ch.column_length);
      compare_field("buffer_index", want.buffer_index, rsp_ch.buffer_index);
      compare_field("request_size", want.request_size, rsp_ch.request_size);
      compare_field("last", want.last, rsp_ch.last);
      compare_field("error", want.error, rsp_ch.error);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cols_setting = TILE_W'(16);
         rows_setting = TILE_W'(16);
         nbuf_setting = NBUF_W'(1);
         tile_order = '0;
         descriptors_due.delete();
         mismatch_count = 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            check_descriptor();
         end
         if (req_ch.valid && req_ch.ready) begin
            predict_partition(req_ch.plane_height, req_ch.plane_width, req_ch.planar_layout,
                              req_ch.channel_count, req_ch.base_address);
         end
         if (csr_we) begin
            case (csr_index)
               CSR_TILE_COLS: begin
                  cols_setting = csr_wdata[TILE_W-1:0];
               end
               CSR_TILE_ROWS: begin
                  rows_setting = csr_wdata[TILE_W-1:0];
               end
               CSR_BUFFER_COUNT: begin
                  nbuf_setting = csr_wdata[NBUF_W-1:0];
               end
               default: begin
               end
            endcase
         end
      end
      pending_count = descriptors_due.size();
   end

endmodule

FILE: verif/tensor_tile_address_generator_top_test.sv
// tensor_tile_address_generator_top_test: drives partition requests and tile
// register writes into the generator, with random gaps on both channels
// depends on tta_pkg, tta_req_if, tta_rsp_if, tta_descriptor_check and the rtl
module tensor_tile_address_generator_top_test;
   import tta_pkg::*;

   localparam int MAX_TILES = 64;
   localparam logic [CSR_IDX_W-1:0] CSR_UNMAPPED = 2'd3;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   int                    mismatch_count;
   int                    pending_count;
   bit                    long_hold_due;
   bit                    long_hold_done;
   bit                    sender_gaps;
   int                    tile_cols_eff;
   int                    tile_rows_eff;

   tta_req_if req_if ();
   tta_rsp_if rsp_if ();

   always #5 clock = ~clock;

   tensor_tile_address_generator_top #(.MAX_TILES(MAX_TILES)) uut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_if),
      .rsp_ch    (rsp_if),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   tta_descriptor_check #(.MAX_TILES(MAX_TILES)) descriptor_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic int tile_extent(input logic [TILE_W-1:0] v);
      if (v == '0) return 1;
      if (v > 9'd256) return 256;
      return int'(v);
   endfunction

   task automatic send_request(input logic [DIM_W-1:0] height, input logic [DIM_W-1:0] width,
                               input logic planar, input logic [DIM_W-1:0] chans,
                               input logic [ADDR_W-1:0] base);
      int gap;
      gap = sender_gaps ? pick_gap() : 0;
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.plane_height <= height;
      req_if.plane_width <= width;
      req_if.planar_layout <= planar;
      req_if.channel_count <= chans;
      req_if.base_address <= base;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] data);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
   endtask

   // block goes idle first: no request in flight, every descriptor delivered
   task automatic configure(input logic [CSR_DATA_W-1:0] cols, input logic [CSR_DATA_W-1:0] rows,
                            input logic [CSR_DATA_W-1:0] nbuf, input bit spare);
      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      write_reg(CSR_TILE_COLS, cols);
      write_reg(CSR_TILE_ROWS, rows);
      write_reg(CSR_BUFFER_COUNT, nbuf);
      if (spare) begin
         write_reg(CSR_UNMAPPED, CSR_DATA_W'($urandom_range(0, 511)));
      end
      csr_we <= 1'b0;
      tile_cols_eff = tile_extent(cols[TILE_W-1:0]);
      tile_rows_eff = tile_extent(rows[TILE_W-1:0]);
   endtask

   function automatic logic [CSR_DATA_W-1:0] pick_tile_setting();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 10) return '0;
      if (roll < 35) return CSR_DATA_W'($urandom_range(1, 8));
      if (roll < 85) return CSR_DATA_W'($urandom_range(9, 256));
      return CSR_DATA_W'($urandom_range(257, 511));
   endfunction

   // mostly grids of up to 8 by 8 tiles with random remainders, some raw noise
   task automatic random_request();
      int roll;
      logic [DIM_W-1:0] height, width;
      roll = $urandom_range(0, 99);
      if (roll < 85) begin
         height = DIM_W'(($urandom_range(1, 8) - 1) * tile_rows_eff
                         + $urandom_range(1, tile_rows_eff));
         width = DIM_W'(($urandom_range(1, 8) - 1) * tile_cols_eff
                        + $urandom_range(1, tile_cols_eff));
      end else begin
         height = DIM_W'($urandom_range(0, 8191));
         width = DIM_W'($urandom_range(0, 8191));
      end
      send_request(height, width, 1'($urandom_range(0, 1)), DIM_W'($urandom_range(0, 8191)),
                   $urandom());
   endtask

   initial begin
      #40_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   // descriptor side back-pressure
   initial begin
      int gap;
      rsp_if.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_due && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_if.ready <= 1'b0;
            repeat (400) @(negedge clock);
         end else begin
            gap = pick_gap();
            if (gap > 0) begin
               rsp_if.ready <= 1'b0;
               repeat (gap) @(negedge clock);
            end
         end
         rsp_if.ready <= 1'b1;
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(30, 60)) @(negedge clock);
         end else begin
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
   end

   initial begin
      req_if.valid = 1'b0;
      req_if.plane_height = '0;
      req_if.plane_width = '0;
      req_if.planar_layout = 1'b0;
      req_if.channel_count = '0;
      req_if.base_address = '0;
      csr_we = 1'b0;
      csr_index = CSR_TILE_COLS;
      csr_wdata = '0;
      sender_gaps = 1'b1;
      tile_cols_eff = 16;
      tile_rows_eff = 16;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset tiling 16 by 16, one buffer
      send_request(13'd1, 13'd1, 1'b1, 13'd1, 32'h0000_0000);
      send_request(13'd128, 13'd128, 1'b0, 13'd4096, 32'hFFFF_FFFF);
      send_request(13'd129, 13'd128, 1'b1, 13'd7, 32'h1234_5678);
      send_request(13'd0, 13'd0, 1'b0, 13'd0, 32'h8000_0000);
      send_request(13'd100, 13'd37, 1'b0, 13'd3, 32'h0000_1000);
      send_request(13'd8191, 13'd8191, 1'b1, 13'd8191, 32'hFFFF_FFFF);
      send_request(13'd16, 13'd1024, 1'b0, 13'd8191, 32'h0000_0000);

      // largest tiles, all buffers
      configure(9'd256, 9'd256, 9'd16, 1'b1);
      send_request(13'd1, 13'd8191, 1'b0, 13'd8191, 32'hDEAD_BEEF);
      send_request(13'd8191, 13'd256, 1'b1, 13'd0, 32'h0000_0000);
      send_request(13'd2048, 13'd2048, 1'b0, 13'd4097, 32'hF000_0000);
      send_request(13'd2049, 13'd2048, 1'b0, 13'd4095, 32'h7FFF_FFFF);

      // zero and oversized register values
      configure(9'd0, 9'd511, 9'd0, 1'b0);
      send_request(13'd300, 13'd20, 1'b0, 13'd2, 32'h0000_0100);

      // upper bits of the buffer count are dropped, leaving 3 buffers
      configure(9'd5, 9'd3, 9'h1E3, 1'b0);
      send_request(13'd20, 13'd11, 1'b1, 13'd1, 32'h0000_0000);
      send_request(13'd24, 13'd50, 1'b0, 13'd5000, 32'hFFFF_FF00);

      for (int p = 0; p < 10; p++) begin
         case (p)
            0: configure(9'd1, 9'd1, 9'd1, 1'b1);
            1: configure(9'd0, 9'd0, 9'd0, 1'b0);
            2: configure(9'd511, 9'd511, 9'd511, 1'b1);
            3: begin
               configure(9'd256, 9'd256, 9'd16, 1'b0);
               long_hold_due = 1'b1;
            end
            default: configure(pick_tile_setting(), pick_tile_setting(),
                               CSR_DATA_W'($urandom_range(0, 511)), 1'($urandom_range(0, 1)));
         endcase
         sender_gaps = (p % 3 != 2);
         repeat (24) random_request();
      end

      req_if.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
